// ===== rtl/tahi_pkg.sv =====
// ----------------------------------------------------------------------------
// tahi_pkg
// shared types and constants of the angle history interpolator
// ----------------------------------------------------------------------------
package tahi_pkg;

  localparam int unsigned HistDepthDef = 256;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_NEWEST = 2'd1,
    ST_TOO_OLD = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] sample_time;
    logic signed [15:0] sample_pitch;
    logic signed [15:0] sample_yaw;
    logic [31:0] ptz_query_time;
    logic [31:0] omni_query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] ptz_pitch;
    logic signed [15:0] ptz_yaw;
    logic [1:0] ptz_status;
    logic signed [15:0] omni_pitch;
    logic signed [15:0] omni_yaw;
    logic [1:0] omni_status;
  } out_item_t;

endpackage

// ===== rtl/tahi_if.sv =====
// ----------------------------------------------------------------------------
// tahi_in_if / tahi_out_if
// valid/ready channels of the angle history interpolator
// ----------------------------------------------------------------------------
interface tahi_in_if;
  import tahi_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tahi_out_if;
  import tahi_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/timestamped_angle_history_interp.sv =====
// ----------------------------------------------------------------------------
// timestamped_angle_history_interp
// gimbal angle history ring with interpolated ptz and omni lookups
//
//   channel | dir | payload
//   in_i    | in  | sample time/pitch/yaw, ptz and omni query times
//   out_o   | out | pitch, yaw, status for ptz and omni
//
// an item is written to the ring, then takes one lookup per query; a lookup
// ends at the newest and oldest entries for newest or too old, else a binary
// search (8 probes at depth 256) brackets the query and, unless it hits exactly,
// two serial divisions (pitch, then yaw) interpolate and set the worst case.
// reset clears ring and queue pointers, sequencer state and output valid; a
// waiting result stalls the engine at its next output, the input queue fills.
// ----------------------------------------------------------------------------
module timestamped_angle_history_interp
  import tahi_pkg::*;
#(
  parameter int unsigned HistDepth = HistDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  tahi_in_if.sink    in_i,
  tahi_out_if.source out_o
);

  logic     q_valid, q_pop;
  in_item_t q_data;

  tahi_front u_front (
    .clk_i, .rst_ni, .in_i,
    .q_valid_o (q_valid),
    .q_data_o  (q_data),
    .q_pop_i   (q_pop)
  );

  tahi_back #(.HistDepth(HistDepth)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .out_o
  );

endmodule

// ===== rtl/tahi_front.sv =====
// ----------------------------------------------------------------------------
// tahi_front
// accepts items into a two-entry queue toward the lookup engine
// ----------------------------------------------------------------------------
module tahi_front
  import tahi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  tahi_in_if.sink  in_i,
  output logic     q_valid_o,
  output in_item_t q_data_o,
  input  logic     q_pop_i
);

  in_item_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_i.data;
  end

endmodule

// ===== rtl/tahi_div.sv =====
// ----------------------------------------------------------------------------
// tahi_div
// restoring divider, one quotient bit per cycle, truncating signed result
// ----------------------------------------------------------------------------
module tahi_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [16:0] diff_i,
  input  logic [31:0]        num_i,
  input  logic [31:0]        den_i,
  output logic               done_o,
  output logic signed [16:0] quo_o
);

  // |quotient| <= |diff| since num < den: 17 quotient bits suffice
  logic [48:0] dvd_q;
  logic [31:0] rem_q, den_q;
  logic [16:0] quo_q;
  logic        neg_q, busy_q;
  logic [5:0]  cnt_q;
  logic [32:0] trial;
  logic [16:0] mag;
  logic [47:0] prod;

  assign mag   = diff_i[16] ? 17'(-diff_i) : 17'(diff_i);
  assign prod  = 48'(mag) * 48'(num_i);
  assign trial = {rem_q, dvd_q[48]} - {1'b0, den_q};
  assign done_o = busy_q && (cnt_q == 6'd0);
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd49;
    end else if (busy_q) begin
      if (cnt_q == 6'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {1'b0, prod};
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= '0;
      neg_q <= diff_i[16];
    end else if (busy_q && cnt_q != 6'd0) begin
      dvd_q <= {dvd_q[47:0], 1'b0};
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[15:0], 1'b1};
      end else begin
        rem_q <= {rem_q[30:0], dvd_q[48]};
        quo_q <= {quo_q[15:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/tahi_back.sv =====
// ----------------------------------------------------------------------------
// tahi_back
// history ring, binary search and interpolation sequencer
// ----------------------------------------------------------------------------
module tahi_back
  import tahi_pkg::*;
#(
  parameter int unsigned HistDepth = HistDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  in_item_t  q_data_i,
  output logic      q_pop_o,
  tahi_out_if.source out_o
);

  localparam int unsigned AW = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int unsigned CW = $clog2(HistDepth + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_RD_NEW, S_RD_OLD, S_CLASS, S_PROBE, S_PROBE_W,
    S_STEP, S_RD_LO, S_RD_HI, S_LOAD, S_DIV_P, S_DIV_Y, S_DONE, S_OUT
  } state_e;

  typedef struct packed {
    logic [31:0] t;
    logic signed [15:0] p;
    logic signed [15:0] y;
  } entry_t;

  entry_t mem_q [HistDepth];
  entry_t rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  state_e      state_q;
  logic [AW-1:0] oldest_q;
  logic [CW-1:0] fill_q;
  in_item_t    item_q;
  logic        which_q;          // 0 ptz, 1 omni
  logic [CW-1:0] lo_q, hi_q;
  entry_t      e_lo_q, e_hi_q;
  entry_t      hi_ent;
  logic signed [15:0] res_p_q, res_y_q;
  logic [1:0]  res_s_q;
  logic signed [15:0] ptz_p_q, ptz_y_q;
  logic [1:0]  ptz_s_q;
  out_item_t   out_q;
  logic        out_v_q;
  logic        out_load;
  logic        div_start;
  logic        div_done;
  logic signed [16:0] div_quo;
  logic signed [16:0] div_diff;
  logic [31:0] qtime;
  logic [CW-1:0] mid, fill_m1, logi;
  logic [CW:0] slot_sum;

  assign qtime   = which_q ? item_q.omni_query_time : item_q.ptz_query_time;
  assign mid     = lo_q + CW'((hi_q - lo_q) >> 1);
  assign fill_m1 = fill_q - CW'(1);

  always_comb begin
    unique case (state_q)
      S_WRITE:  logi = (fill_q < CW'(HistDepth)) ? fill_q : '0;
      S_RD_NEW: logi = fill_m1;
      S_PROBE:  logi = mid;
      S_RD_HI:  logi = hi_q;
      S_RD_LO:  logi = lo_q;
      default:  logi = '0;
    endcase
    slot_sum = (CW+1)'(oldest_q) + (CW+1)'(logi);
    if (slot_sum >= (CW+1)'(HistDepth)) slot_sum = slot_sum - (CW+1)'(HistDepth);
    rd_addr = AW'(slot_sum);
  end

  assign wr_en = (state_q == S_WRITE);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[rd_addr] <= '{item_q.sample_time, item_q.sample_pitch, item_q.sample_yaw};
    rd_q <= mem_q[rd_addr];
  end

  // upper bracket entry arrives from the ring in the load state
  assign hi_ent    = (state_q == S_LOAD) ? rd_q : e_hi_q;
  assign div_diff  = (state_q == S_LOAD)
                   ? 17'(hi_ent.p) - 17'(e_lo_q.p) : 17'(hi_ent.y) - 17'(e_lo_q.y);
  assign div_start = (state_q == S_LOAD) || (state_q == S_DIV_P && div_done);

  tahi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .diff_i  (div_diff),
    .num_i   (qtime - e_lo_q.t),
    .den_i   (hi_ent.t - e_lo_q.t),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign out_load    = (state_q == S_OUT) && (!out_v_q || out_o.ready);
  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      oldest_q <= '0;
      fill_q   <= '0;
      which_q  <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (out_v_q && out_o.ready && !out_load) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (q_pop_o) begin
          item_q  <= q_data_i;
          which_q <= 1'b0;
          state_q <= S_WRITE;
        end
        S_WRITE: begin
          if (fill_q < CW'(HistDepth)) fill_q <= fill_q + CW'(1);
          else oldest_q <= (oldest_q == AW'(HistDepth - 1)) ? '0 : oldest_q + AW'(1);
          state_q <= S_RD_NEW;
        end
        S_RD_NEW: state_q <= S_RD_OLD;
        S_RD_OLD: begin
          e_hi_q  <= rd_q;
          state_q <= S_CLASS;
        end
        S_CLASS: begin
          e_lo_q <= rd_q;
          lo_q   <= '0;
          hi_q   <= fill_m1;
          if (qtime >= e_hi_q.t) begin
            res_p_q <= e_hi_q.p; res_y_q <= e_hi_q.y; res_s_q <= ST_NEWEST;
            state_q <= S_DONE;
          end else if (qtime < rd_q.t) begin
            res_p_q <= '0; res_y_q <= '0; res_s_q <= ST_TOO_OLD;
            state_q <= S_DONE;
          end else begin
            res_s_q <= ST_INTERP;
            state_q <= S_STEP;
          end
        end
        S_STEP: state_q <= (hi_q - lo_q > CW'(1)) ? S_PROBE : S_RD_LO;
        S_PROBE: state_q <= S_PROBE_W;
        S_PROBE_W: begin
          if (rd_q.t <= qtime) lo_q <= mid;
          else hi_q <= mid;
          state_q <= S_STEP;
        end
        S_RD_LO: state_q <= S_RD_HI;
        S_RD_HI: begin
          e_lo_q  <= rd_q;
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          e_hi_q <= rd_q;
          if (e_lo_q.t == qtime) begin
            res_p_q <= e_lo_q.p; res_y_q <= e_lo_q.y;
            state_q <= S_DONE;
          end else state_q <= S_DIV_P;
        end
        S_DIV_P: if (div_done) begin
          res_p_q <= e_lo_q.p + 16'(div_quo);
          state_q <= S_DIV_Y;
        end
        S_DIV_Y: if (div_done) begin
          res_y_q <= e_lo_q.y + 16'(div_quo);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!which_q) begin
            ptz_p_q <= res_p_q;
            ptz_y_q <= res_y_q;
            ptz_s_q <= res_s_q;
            which_q <= 1'b1;
            state_q <= S_RD_NEW;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: if (out_load) begin
          out_q   <= '{ptz_p_q, ptz_y_q, ptz_s_q, res_p_q, res_y_q, res_s_q};
          out_v_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/tahi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tahi_checker
// watches both channels, keeps its own copy of the sample history, predicts
// the ptz and omni lookups for every accepted item and compares results
// ----------------------------------------------------------------------------
module tahi_checker
  import tahi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned Depth = HistDepthDef;

  logic [31:0]        hist_time [Depth];
  logic signed [15:0] hist_pitch[Depth];
  logic signed [15:0] hist_yaw  [Depth];
  int unsigned        oldest;
  int unsigned        fill;
  out_item_t          lookup_q[$];

  function automatic int unsigned slot_at(int unsigned i);
    return (oldest + i) % Depth;
  endfunction

  function automatic logic signed [15:0] lerp(logic signed [15:0] a0, logic signed [15:0] a1,
                                              logic [31:0] q, logic [31:0] t0,
                                              logic [31:0] t1);
    longint num;
    longint den;
    num = (longint'(a1) - longint'(a0)) * longint'({32'd0, q - t0});
    den = longint'({32'd0, t1 - t0});
    if (den <= 0) return a0;
    return 16'(a0 + num / den);
  endfunction

  task automatic find_angles(input logic [31:0] q, output logic signed [15:0] p,
                             output logic signed [15:0] y, output logic [1:0] st);
    int unsigned lo, hi, mid, slo, shi, nw, od;
    p = '0;
    y = '0;
    st = ST_TOO_OLD;
    if (fill == 0) return;
    nw = slot_at(fill - 1);
    od = slot_at(0);
    if (q >= hist_time[nw]) begin
      p = hist_pitch[nw];
      y = hist_yaw[nw];
      st = ST_NEWEST;
      return;
    end
    if (q < hist_time[od]) return;
    lo = 0;
    hi = fill - 1;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (hist_time[slot_at(mid)] <= q) lo = mid;
      else hi = mid;
    end
    slo = slot_at(lo);
    shi = slot_at(hi);
    st = ST_INTERP;
    if (hist_time[slo] == q) begin
      p = hist_pitch[slo];
      y = hist_yaw[slo];
    end else begin
      p = lerp(hist_pitch[slo], hist_pitch[shi], q, hist_time[slo], hist_time[shi]);
      y = lerp(hist_yaw[slo], hist_yaw[shi], q, hist_time[slo], hist_time[shi]);
    end
  endtask

  task automatic add_sample(input in_item_t it);
    int unsigned s;
    out_item_t   e;
    if (fill < Depth) begin
      s = slot_at(fill);
      fill++;
    end else begin
      s = oldest;
      oldest = slot_at(1);
    end
    hist_time[s]  = it.sample_time;
    hist_pitch[s] = it.sample_pitch;
    hist_yaw[s]   = it.sample_yaw;
    find_angles(it.ptz_query_time, e.ptz_pitch, e.ptz_yaw, e.ptz_status);
    find_angles(it.omni_query_time, e.omni_pitch, e.omni_yaw, e.omni_status);
    lookup_q = {lookup_q, e};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      oldest = 0;
      fill = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      lookup_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) add_sample(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (lookup_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected item %h", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = lookup_q.pop_front();
          if (e !== out_data_i) begin
            if (fail_count_o < 10)
              $display("expected p %0d %0d %0d o %0d %0d %0d got p %0d %0d %0d o %0d %0d %0d",
                       e.ptz_pitch, e.ptz_yaw, e.ptz_status, e.omni_pitch, e.omni_yaw,
                       e.omni_status, out_data_i.ptz_pitch, out_data_i.ptz_yaw,
                       out_data_i.ptz_status, out_data_i.omni_pitch, out_data_i.omni_yaw,
                       out_data_i.omni_status);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= lookup_q.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives gimbal samples with ptz and omni query times into the angle history
// interpolator, with random gaps and output stalls; the checker predicts
// ----------------------------------------------------------------------------
module testbench;
  import tahi_pkg::*;

  localparam int unsigned NumRandom = 1530;
  localparam int unsigned Patience = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles;
  logic [31:0] now_time;
  logic [31:0] first_time;

  tahi_in_if  in_ch();
  tahi_out_if out_ch();

  timestamped_angle_history_interp DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  tahi_checker checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_data_i   (in_ch.data),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_i  (out_ch.data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(150, 20);
  endfunction

  // output stalls, with stretches of none
  initial begin
    int unsigned n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = ($urandom_range(3) == 0) ? 0 : gap_len();
      out_ch.ready <= (n == 0);
      repeat (n == 0 ? $urandom_range(40, 1) : n) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > Patience) begin
      $display("timestamped_angle_history_interp: mismatch");
      $finish;
    end
  end

  task automatic send(input in_item_t it);
    int unsigned n;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    n = gap_len();
    if (n != 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // stop sending and wait until every expected result has come
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_query();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return $urandom();
    if (r == 1) return now_time + $urandom_range(50);
    if (r == 2) return first_time - $urandom_range(20);
    if (r < 4 || now_time == first_time || now_time + 32'd1 == first_time)
      return now_time - $urandom_range(300);
    return first_time + ($urandom() % (now_time - first_time + 1));
  endfunction

  initial begin
    in_item_t it;
    int unsigned w;
    idle_cycles = 0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, exact hits, too old, newest, out-of-order times
    send('{32'd100, 16'sh7fff, -16'sh8000, 32'd0, 32'hffffffff});
    send('{32'd200, -16'sh8000, 16'sh7fff, 32'd150, 32'd100});
    send('{32'd300, 16'sh0000, 16'sh0000, 32'd99, 32'd200});
    send('{32'd300, 16'sh1234, -16'sh1234, 32'd300, 32'd299});
    send('{32'd250, 16'sh0100, 16'sh0200, 32'd260, 32'd101});
    send('{32'hffffffff, 16'sh7fff, 16'sh7fff, 32'hfffffffe, 32'd0});
    send('{32'hffffffff, -16'sh8000, -16'sh8000, 32'h80000000, 32'd250});
    send('{32'd0, 16'sh5555, -16'sh5556, 32'd0, 32'h7fffffff});
    send('{32'd0, -16'sh0001, 16'sh0001, 32'haaaaaaaa, 32'h55555555});

    // wait for the pipe to drain before the random part
    drain();
    repeat (200) @(posedge clk_i);

    now_time = $urandom_range(1000);
    first_time = now_time;
    for (int unsigned i = 0; i < NumRandom; i++) begin
      w = $urandom_range(99);
      if (w < 90) now_time = now_time + $urandom_range(w < 5 ? 100000 : 40);
      else if (w < 95) now_time = now_time - $urandom_range(30);
      if (i > 256) first_time = now_time - 256 * 20;
      it.sample_time = (w >= 97) ? $urandom() : now_time;
      it.sample_pitch = 16'($urandom());
      it.sample_yaw = 16'($urandom());
      it.ptz_query_time = pick_query();
      it.omni_query_time = pick_query();
      send(it);
      if (i == NumRandom / 2) drain();
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("timestamped_angle_history_interp: match");
    else $display("timestamped_angle_history_interp: mismatch");
    $finish;
  end

endmodule
